// ===== hw/rtl/tbl_pkg.sv =====
`timescale 1ns / 1ps
// Package for the token bucket limiter: field widths, kind/status/register codes,
// reset values and the beat structs of the input and result channels.
// No dependencies.
package tbl_pkg;

  localparam int TOKEN_BITS    = 20;
  localparam int FRAC_BITS_DEF = 16;
  localparam int RATE_BITS     = 32;
  localparam int TICK_BITS     = 16;
  localparam int CODE_BITS     = 2;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CODE_BITS-1:0] KIND_UPDATE  = 2'd0;
  localparam logic [CODE_BITS-1:0] KIND_CONSUME = 2'd1;
  localparam logic [CODE_BITS-1:0] KIND_CHECK   = 2'd2;

  localparam logic [CODE_BITS-1:0] STATUS_OK    = 2'd0;
  localparam logic [CODE_BITS-1:0] STATUS_SHORT = 2'd1;
  localparam logic [CODE_BITS-1:0] STATUS_ZERO  = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_RATE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_MAX  = 2'd1;

  localparam logic [RATE_BITS-1:0]  RATE_RESET = 32'd65536;
  localparam logic [TOKEN_BITS-1:0] MAX_RESET  = TOKEN_BITS'(65535);

  typedef struct packed {
    logic [CODE_BITS-1:0]  kind;
    logic [TICK_BITS-1:0]  tick_gap;
    logic [TOKEN_BITS-1:0] req_size;
  } in_beat_t;

  typedef struct packed {
    logic [CODE_BITS-1:0]  status;
    logic [TOKEN_BITS-1:0] token_level;
  } out_beat_t;

endpackage

// ===== hw/rtl/token_bucket_limiter_core.sv =====
`timescale 1ns / 1ps
// Token bucket limiter core: one rate decision per beat, 32-bit fixed-point rate.
// Depends on tbl_pkg for widths, codes, reset values and beat structs.
//
//   channel | signals                                   | direction
//   in      | in_valid, in_stall, in_data (in_beat_t)   | beat in
//   out     | out_valid, out_stall, out_data (out_beat_t)| beat out
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_wdata| register write
//
// A beat is registered, then decided combinationally (one 32x16 multiply, adds and
// compares) while the bucket state updates; its result shows the next cycle.
// Throughput is one beat per cycle while the output register is not stalled.
// Synchronous active-low reset restores the config and state registers and fills the bucket.
// in_stall rises only while a registered beat waits behind a stalled output register.
// cfg_ready is always high.
module token_bucket_limiter_core #(
  parameter int FRAC_BITS = tbl_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  tbl_pkg::in_beat_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output tbl_pkg::out_beat_t                 out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tbl_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [tbl_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  localparam int TB     = tbl_pkg::TOKEN_BITS;
  localparam int PROD_W = tbl_pkg::RATE_BITS + tbl_pkg::TICK_BITS;
  localparam int SUM_W  = ((PROD_W > FRAC_BITS) ? PROD_W : FRAC_BITS) + 1;
  localparam int CAP_W  = TB + 1 + FRAC_BITS;
  localparam int CMP_W  = (SUM_W > CAP_W) ? SUM_W : CAP_W;
  localparam int WHOLE_W = TB + 1;
  localparam int LVL_W  = TB + 2;

  logic [tbl_pkg::RATE_BITS-1:0] rate_r;
  logic [TB-1:0]                 max_r;
  logic [TB-1:0]                 count_r;
  logic [TB-1:0]                 count_nxt;
  logic [FRAC_BITS-1:0]          frac_r;
  logic [FRAC_BITS-1:0]          frac_nxt;
  logic                          in_valid_r;
  tbl_pkg::in_beat_t             in_r;
  logic                          out_valid_r;
  tbl_pkg::out_beat_t            out_r;
  tbl_pkg::out_beat_t            out_nxt;

  logic                          advance;
  logic                          in_fire;
  logic                          proc;
  logic [PROD_W-1:0]             prod;
  logic [CMP_W-1:0]              sum;
  logic [CMP_W-1:0]              cap;
  logic [CMP_W-1:0]              capped;
  logic [WHOLE_W-1:0]            whole;
  logic [LVL_W-1:0]              level;
  logic [TB-1:0]                 sat;
  logic                          repl_ok;
  logic [TB-1:0]                 count_rep;
  logic [FRAC_BITS-1:0]          frac_rep;
  logic [TB-1:0]                 diff;
  logic                          short;

  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = in_valid_r && !advance;
  assign in_fire   = in_valid && !in_stall;
  assign proc      = in_valid_r && advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    prod    = PROD_W'(rate_r) * PROD_W'(in_r.tick_gap);
    sum     = CMP_W'(frac_r) + CMP_W'(prod);
    cap     = CMP_W'({max_r, 1'b0}) << FRAC_BITS;
    capped  = (sum > cap) ? (CMP_W'(max_r) << FRAC_BITS) : sum;
    whole   = capped[FRAC_BITS +: WHOLE_W];
    level   = LVL_W'(count_r) + LVL_W'(whole);
    sat     = (level > LVL_W'(max_r)) ? max_r : level[TB-1:0];
    repl_ok = (in_r.tick_gap != '0) && (rate_r != '0);
    count_rep = repl_ok ? sat : count_r;
    frac_rep  = repl_ok ? capped[FRAC_BITS-1:0] : frac_r;
    diff    = count_rep - in_r.req_size;
    short   = (count_rep < in_r.req_size) || (diff > max_r);

    count_nxt      = count_r;
    frac_nxt       = frac_r;
    out_nxt.status = tbl_pkg::STATUS_OK;
    unique case (in_r.kind)
      tbl_pkg::KIND_UPDATE: begin
        count_nxt = count_rep;
        frac_nxt  = frac_rep;
      end
      tbl_pkg::KIND_CONSUME: begin
        if (in_r.req_size == '0) begin
          out_nxt.status = tbl_pkg::STATUS_ZERO;
        end else begin
          frac_nxt = frac_rep;
          if (short) begin
            count_nxt      = count_rep;
            out_nxt.status = tbl_pkg::STATUS_SHORT;
          end else begin
            count_nxt = diff;
          end
        end
      end
      tbl_pkg::KIND_CHECK: begin
        if (count_r < in_r.req_size) begin
          out_nxt.status = tbl_pkg::STATUS_SHORT;
        end
      end
      default: begin
      end
    endcase
    out_nxt.token_level = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r      <= tbl_pkg::RATE_RESET;
      max_r       <= tbl_pkg::MAX_RESET;
      count_r     <= tbl_pkg::MAX_RESET;
      frac_r      <= '0;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tbl_pkg::CFG_IDX_RATE) begin
          rate_r <= cfg_wdata[tbl_pkg::RATE_BITS-1:0];
        end else if (cfg_index == tbl_pkg::CFG_IDX_MAX) begin
          max_r <= cfg_wdata[TB-1:0];
        end
      end
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (proc) begin
        count_r     <= count_nxt;
        frac_r      <= frac_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_r <= in_data;
    end
    if (proc) begin
      out_r <= out_nxt;
    end
  end

endmodule
